// ===== design/robust_signal_threshold_estimator_top_defines.svh =====
// Assertion macros shared by the threshold estimator RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ROBUST_SIGNAL_THRESHOLD_ESTIMATOR_TOP_DEFINES_SVH
`define ROBUST_SIGNAL_THRESHOLD_ESTIMATOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RSTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define RSTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== design/rste_pkg.sv =====
// Types shared by the threshold estimator top level and its divide/sqrt unit.
// No dependencies.
`timescale 1ns / 1ps

package rste_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RING,
    ST_EV_HIST,
    ST_EV_WR,
    ST_INS,
    ST_INS_WR,
    ST_SW1,
    ST_QUART,
    ST_SW2,
    ST_MUL1,
    ST_MUL2,
    ST_SQ_GO,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== design/robust_signal_threshold_estimator_top.sv =====
// Robust signal threshold estimator: top level with ring, histogram and sequencer.
// Depends on rste_pkg, rste_divsqrt and the assertion macro header.
`timescale 1ns / 1ps
`include "robust_signal_threshold_estimator_top_defines.svh"

// Each accepted nonzero magnitude enters a window of the most recent window_len
// samples; one result (threshold_mag, kept_count) follows per sample, a zero sample
// is taken and dropped. An item's work covers E evictions (one in steady state),
// two passes over the histogram memory (one read a cycle, for the quartiles and then
// for the trimmed sums) and the shared bit-serial unit, which runs the square root
// and then the divide; AW = 2*ceil((CW + QW + 4)/2) is the root/divide operand width.
// in_ready_o is high only between items; a finished result waits in the output
// register while the next item is taken.

module robust_signal_threshold_estimator_top #(
  parameter int MAX_WINDOW = 1024,
  parameter int MAG_LEVELS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [6:0]  sample_mag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  threshold_mag_o,
  output logic [10:0] kept_count_o
);

  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int RAW = $clog2(MAX_WINDOW);
  localparam int MW  = $clog2(MAG_LEVELS);
  localparam int SW  = CW + MW;
  localparam int QW  = CW + 2 * MW;
  localparam int DW  = CW + QW;
  localparam int AW  = ((DW + 5) / 2) * 2;
  localparam int RW  = AW / 2;
  localparam int KW  = CW + 2;
  localparam int LW  = MW + 3;
  localparam logic [RAW-1:0] WP_LAST = RAW'(MAX_WINDOW - 1);
  localparam logic [MW-1:0]  V_TOP   = MW'(MAG_LEVELS - 1);

  rste_pkg::state_e state_q, state_d;

  logic [10:0]     cfg_q;
  logic [CW-1:0]   fill_q, fill_d;
  logic [RAW-1:0]  wp_q, wp_d;
  logic [MW-1:0]   s_q, s_d;

  // memories
  logic [MW-1:0]   ring_mem [MAX_WINDOW];
  logic [MW-1:0]   ring_rd_q;
  logic            ring_we;
  logic [RAW-1:0]  ring_ra;
  logic [CW-1:0]   hist_mem [MAG_LEVELS];
  logic [MAG_LEVELS-1:0] hist_vld_q;
  logic [CW-1:0]   hist_rd_q;
  logic            hist_we;
  logic [MW-1:0]   hist_ra, hist_wa;
  logic [CW-1:0]   hist_wd;

  // sweep pipeline
  logic [MW:0]     sw_a_q, sw_a_d;
  logic [2*MW-1:0] sw_sq_q, sw_sq_d;
  logic            issue;
  logic            d1_vld_q;
  logic [MW-1:0]   d1_v_q;
  logic [2*MW-1:0] d1_sq_q;
  logic            p_vld_q, p_vld_d;
  logic [CW-1:0]   p_h_q;
  logic [SW-1:0]   p_hv_q;
  logic [QW-1:0]   p_hsq_q;

  // quartile search
  logic [KW-1:0]   cum_q, cum_d, cum_new;
  logic [KW-1:0]   k_ref [4];
  logic [MW-1:0]   qv_q [4];
  logic [MW-1:0]   qv_d [4];
  logic [3:0]      qf_q, qf_d;
  logic [KW-1:0]   n_ext, n3;
  logic signed [LW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [LW-1:0] q1s, q3s, vs;
  logic [MW:0]     q1sum, q3sum;
  logic            in_range;

  // sums and final arithmetic
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [QW-1:0]   sq_q, sq_d;
  logic [DW-1:0]   prod_q, prod_d;
  logic [DW-1:0]   d_q, d_d;
  logic [CW-1:0]   wl;
  logic [RAW-1:0]  ev_pos;
  logic [AW-1:0]   xdiv;
  logic [AW-1:0]   quo;
  logic [6:0]      best;
  logic [8:0]      q_inc;

  logic            out_valid_q, out_valid_d;
  logic [6:0]      thr_q, thr_d;
  logic [10:0]     kept_q, kept_d;

  rste_pkg::unit_ctrl_t ctrl;
  rste_pkg::unit_stat_t stat;
  logic [AW-1:0]   u_opa;
  logic [AW-1:0]   u_res;

  rste_divsqrt #(
    .AW(AW),
    .BW(CW)
  ) u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .opa_i  (u_opa),
    .opb_i  (cnt_q),
    .res_o  (u_res),
    .stat_o (stat)
  );

  always_comb begin
    if (cfg_q == 11'd0) begin
      wl = CW'(1);
    end else if (32'(cfg_q) > 32'(MAX_WINDOW)) begin
      wl = CW'(MAX_WINDOW);
    end else begin
      wl = CW'(cfg_q);
    end
    if (32'(wp_q) >= 32'(fill_q)) begin
      ev_pos = RAW'(32'(wp_q) - 32'(fill_q));
    end else begin
      ev_pos = RAW'(32'(wp_q) + 32'(MAX_WINDOW) - 32'(fill_q));
    end
  end

  // order statistic indexes for both quartiles
  always_comb begin
    n_ext = KW'(fill_q);
    n3    = n_ext + (n_ext << 1);
    if (n_ext[1:0] == 2'b00) begin
      k_ref[1] = n_ext >> 2;
      k_ref[0] = k_ref[1] - KW'(1);
      k_ref[3] = n3 >> 2;
      k_ref[2] = k_ref[3] - KW'(1);
    end else begin
      k_ref[0] = ((n_ext + KW'(3)) >> 2) - KW'(1);
      k_ref[1] = k_ref[0];
      k_ref[2] = ((n3 + KW'(3)) >> 2) - KW'(1);
      k_ref[3] = k_ref[2];
    end
  end

  always_comb begin
    q1sum    = (MW + 1)'(qv_q[0]) + (MW + 1)'(qv_q[1]);
    q3sum    = (MW + 1)'(qv_q[2]) + (MW + 1)'(qv_q[3]);
    q1s      = $signed(LW'(q1sum[MW:1]));
    q3s      = $signed(LW'(q3sum[MW:1]));
    vs       = $signed(LW'(d1_v_q));
    in_range = (vs >= lo_q) && (vs <= hi_q);
    cum_new  = cum_q + KW'(hist_rd_q);
    issue    = ((state_q == rste_pkg::ST_SW1) || (state_q == rste_pkg::ST_SW2)) &&
               (32'(sw_a_q) < 32'(MAG_LEVELS));
    xdiv     = AW'({sum_q, 1'b0}) + AW'(u_res[RW-1:0]);
    quo      = u_res;
    q_inc    = 9'(quo[7:0]) + 9'd1;
    if (cnt_q == '0) begin
      best = 7'd0;
    end else if (quo >= AW'(253)) begin
      best = 7'd127;
    end else begin
      best = q_inc[7:1];
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wp_d        = wp_q;
    s_d         = s_q;
    ring_we     = 1'b0;
    ring_ra     = ev_pos;
    hist_we     = 1'b0;
    hist_ra     = sw_a_q[MW-1:0];
    hist_wa     = s_q;
    hist_wd     = hist_rd_q + CW'(1);
    sw_a_d      = sw_a_q;
    sw_sq_d     = sw_sq_q;
    cum_d       = cum_q;
    qv_d        = qv_q;
    qf_d        = qf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    prod_d      = prod_q;
    d_d         = d_q;
    p_vld_d     = 1'b0;
    ctrl.start  = 1'b0;
    ctrl.op     = rste_pkg::OP_SQRT;
    u_opa       = AW'({d_q, 4'b0000});
    out_valid_d = out_valid_q && !out_ready_i;
    thr_d       = thr_q;
    kept_d      = kept_q;
    in_ready_o  = 1'b0;

    if (issue) begin
      sw_a_d  = sw_a_q + (MW + 1)'(1);
      sw_sq_d = sw_sq_q + (2 * MW)'({sw_a_q, 1'b1});
    end

    unique case (state_q)
      rste_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (sample_mag_i != 7'd0)) begin
          s_d     = (32'(sample_mag_i) >= 32'(MAG_LEVELS)) ? V_TOP : MW'(sample_mag_i);
          state_d = (fill_q >= wl) ? rste_pkg::ST_EV_RING : rste_pkg::ST_INS;
        end
      end
      rste_pkg::ST_EV_RING: begin
        state_d = rste_pkg::ST_EV_HIST;
      end
      rste_pkg::ST_EV_HIST: begin
        hist_ra = ring_rd_q;
        state_d = rste_pkg::ST_EV_WR;
      end
      rste_pkg::ST_EV_WR: begin
        hist_we = 1'b1;
        hist_wa = ring_rd_q;
        hist_wd = (hist_rd_q != '0) ? hist_rd_q - CW'(1) : hist_rd_q;
        fill_d  = fill_q - CW'(1);
        state_d = ((fill_q - CW'(1)) >= wl) ? rste_pkg::ST_EV_RING : rste_pkg::ST_INS;
      end
      rste_pkg::ST_INS: begin
        ring_we = 1'b1;
        hist_ra = s_q;
        state_d = rste_pkg::ST_INS_WR;
      end
      rste_pkg::ST_INS_WR: begin
        hist_we = 1'b1;
        wp_d    = (wp_q == WP_LAST) ? '0 : wp_q + RAW'(1);
        fill_d  = fill_q + CW'(1);
        sw_a_d  = '0;
        sw_sq_d = '0;
        cum_d   = '0;
        qf_d    = '0;
        for (int i = 0; i < 4; i++) qv_d[i] = V_TOP;
        state_d = rste_pkg::ST_SW1;
      end
      rste_pkg::ST_SW1: begin
        if (d1_vld_q) begin
          cum_d = cum_new;
          for (int i = 0; i < 4; i++) begin
            if (!qf_q[i] && (cum_new > k_ref[i])) begin
              qf_d[i] = 1'b1;
              qv_d[i] = d1_v_q;
            end
          end
        end
        if (!issue && !d1_vld_q) state_d = rste_pkg::ST_QUART;
      end
      rste_pkg::ST_QUART: begin
        lo_d    = (q1s <<< 1) - q3s;
        hi_d    = (q3s <<< 1) - q1s;
        sw_a_d  = '0;
        sw_sq_d = '0;
        cnt_d   = '0;
        sum_d   = '0;
        sq_d    = '0;
        state_d = rste_pkg::ST_SW2;
      end
      rste_pkg::ST_SW2: begin
        p_vld_d = d1_vld_q && in_range;
        if (p_vld_q) begin
          cnt_d = cnt_q + p_h_q;
          sum_d = sum_q + p_hv_q;
          sq_d  = sq_q + p_hsq_q;
        end
        if (!issue && !d1_vld_q && !p_vld_q) state_d = rste_pkg::ST_MUL1;
      end
      rste_pkg::ST_MUL1: begin
        prod_d  = DW'(cnt_q) * DW'(sq_q);
        state_d = rste_pkg::ST_MUL2;
      end
      rste_pkg::ST_MUL2: begin
        d_d     = prod_q - DW'(DW'(sum_q) * DW'(sum_q));
        state_d = rste_pkg::ST_SQ_GO;
      end
      rste_pkg::ST_SQ_GO: begin
        ctrl.start = 1'b1;
        ctrl.op    = rste_pkg::OP_SQRT;
        state_d    = rste_pkg::ST_SQRT;
      end
      rste_pkg::ST_SQRT: begin
        if (stat.done) begin
          ctrl.start = 1'b1;
          ctrl.op    = rste_pkg::OP_DIV;
          u_opa      = xdiv;
          state_d    = rste_pkg::ST_DIV;
        end
      end
      rste_pkg::ST_DIV: begin
        if (stat.done) state_d = rste_pkg::ST_DONE;
      end
      rste_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          thr_d       = best;
          kept_d      = 11'(cnt_q);
          state_d     = rste_pkg::ST_IDLE;
        end
      end
      default: state_d = rste_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rste_pkg::ST_IDLE;
      cfg_q       <= 11'd1000;
      fill_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      d1_vld_q    <= 1'b0;
      p_vld_q     <= 1'b0;
      hist_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      d1_vld_q    <= issue;
      p_vld_q     <= p_vld_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (hist_we) hist_vld_q[hist_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    sw_a_q  <= sw_a_d;
    sw_sq_q <= sw_sq_d;
    d1_v_q  <= sw_a_q[MW-1:0];
    d1_sq_q <= sw_sq_q;
    p_h_q   <= hist_rd_q;
    p_hv_q  <= SW'(hist_rd_q) * SW'(d1_v_q);
    p_hsq_q <= QW'(hist_rd_q) * QW'(d1_sq_q);
    cum_q   <= cum_d;
    qv_q    <= qv_d;
    qf_q    <= qf_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    sq_q    <= sq_d;
    prod_q  <= prod_d;
    d_q     <= d_d;
    thr_q   <= thr_d;
    kept_q  <= kept_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wp_q] <= s_q;
    ring_rd_q <= ring_mem[ring_ra];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_q <= hist_vld_q[hist_ra] ? hist_mem[hist_ra] : '0;
  end

  assign out_valid_o     = out_valid_q;
  assign threshold_mag_o = thr_q;
  assign kept_count_o    = kept_q;

  `RSTE_ASSERT(a_fill_cap, fill_q <= CW'(MAX_WINDOW), "window fill above capacity")
  `RSTE_ASSERT(a_busy_after_take, (in_valid_i && in_ready_o && sample_mag_i != 7'd0) |=> !in_ready_o, "ready while an item is in work")
  `RSTE_ASSERT(a_kept_nonzero, (state_q == rste_pkg::ST_DONE) |-> (cnt_q != '0), "trimmed window is empty")
  `RSTE_ASSERT(a_unit_start_idle, ctrl.start |-> !stat.busy, "unit started while busy")

endmodule

// ===== design/rste_divsqrt.sv =====
// Shared restoring unit: integer square root or integer divide, one bit a cycle.
// Uses rste_pkg for its control and status structs.
`timescale 1ns / 1ps

module rste_divsqrt #(
  parameter int AW = 40,
  parameter int BW = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rste_pkg::unit_ctrl_t ctrl_i,
  input  logic [AW-1:0]       opa_i,
  input  logic [BW-1:0]       opb_i,
  output logic [AW-1:0]       res_o,
  output rste_pkg::unit_stat_t stat_o
);

  localparam int UW = AW / 2 + BW + 2;
  localparam int NW = $clog2(AW + 1);

  logic [AW-1:0]     src_q, src_d;
  logic [UW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     res_q, res_d;
  logic [BW-1:0]     div_q, div_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  rste_pkg::unit_op_e op_q, op_d;

  logic [UW-1:0]     shifted;
  logic [UW-1:0]     trial;
  logic              ge;

  always_comb begin
    if (op_q == rste_pkg::OP_SQRT) begin
      shifted = {rem_q[UW-3:0], src_q[AW-1:AW-2]};
      trial   = UW'({res_q, 2'b01});
    end else begin
      shifted = {rem_q[UW-2:0], src_q[AW-1]};
      trial   = UW'(div_q);
    end
    ge = (shifted >= trial);
  end

  always_comb begin
    src_d  = src_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    if (ctrl_i.start) begin
      src_d  = opa_i;
      rem_d  = '0;
      res_d  = '0;
      div_d  = opb_i;
      op_d   = ctrl_i.op;
      cnt_d  = (ctrl_i.op == rste_pkg::OP_SQRT) ? NW'(AW / 2) : NW'(AW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (shifted - trial) : shifted;
      res_d = {res_q[AW-2:0], ge};
      src_d = (op_q == rste_pkg::OP_SQRT) ? {src_q[AW-3:0], 2'b00} : {src_q[AW-2:0], 1'b0};
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rste_pkg::OP_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
    res_q <= res_d;
    div_q <= div_d;
  end

  assign res_o       = res_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
